// ----- design/scte_pkg.sv -----
// Shared constants, event word type and the scancode to key code table
// for the scancode to key event block. No dependencies.
package scte_pkg;

  localparam int KEY_COUNT_DEF = 89;
  localparam int EVQ_DEPTH     = 8;

  localparam logic [7:0] PRESS_MAX   = 8'h58;
  localparam logic [7:0] RELEASE_MIN = 8'h80;
  localparam logic [7:0] RELEASE_MAX = 8'hD8;

  localparam logic TYPE_SYNC = 1'b0;
  localparam logic TYPE_KEY  = 1'b1;

  localparam logic [1:0] VAL_RELEASE = 2'd0;
  localparam logic [1:0] VAL_PRESS   = 2'd1;
  localparam logic [1:0] VAL_REPEAT  = 2'd2;

  typedef struct packed {
    logic       etype;
    logic [7:0] code;
    logic [1:0] value;
    logic       last;
  } event_word_t;

  // Set-1 key index to input key code; 0 means unmapped.
  function automatic logic [7:0] key_code_lookup(input logic [6:0] idx);
    logic [7:0] code;
    case (idx)
      7'd0, 7'd84, 7'd85, 7'd86: code = 8'd0;
      7'd72: code = 8'd103;
      7'd75: code = 8'd105;
      7'd77: code = 8'd106;
      7'd80: code = 8'd108;
      7'd82: code = 8'd110;
      7'd83: code = 8'd111;
      default: code = (idx <= 7'd88) ? {1'b0, idx} : 8'd0;
    endcase
    return code;
  endfunction

endpackage

// ----- design/scancode_to_key_event.sv -----
// Scancode to key event top level: decode, key map read-modify-write, event queue.
// The first event of a scancode is registered in stage 1 and then in the event
// queue before it is offered.
// Throughput: one scancode per cycle when it yields at most one event word and
// out_ready is high; two-word ones wait on the one-word-per-cycle queue output.
// Reset: synchronous; clears key map valid flops at once (no sweep), last code 0.
module scancode_to_key_event
  import scte_pkg::*;
#(
  parameter int KEY_COUNT = KEY_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] scancode,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       event_type,
  output logic [7:0] event_code,
  output logic [1:0] event_value,
  output logic       last_of_run
);

  localparam int IDX_W = $clog2(KEY_COUNT);
  localparam int CNT_W = $clog2(EVQ_DEPTH + 1);

  logic             in_accept;
  logic             dec_press;
  logic             dec_release;
  logic [7:0]       dec_key;
  logic             dec_ok;

  logic             s1_valid;
  logic             s1_press;
  logic [IDX_W-1:0] s1_idx;
  logic [7:0]       s1_key;

  logic             fwd_valid;
  logic [IDX_W-1:0] fwd_idx;
  logic             fwd_bit;

  logic             mem_rd_bit;
  logic             down;
  logic [7:0]       last_pressed;
  logic             set_last;
  logic [1:0]       key_val;

  logic [1:0]       push_n;
  event_word_t      push_w0;
  event_word_t      push_w1;
  event_word_t      head;
  logic [CNT_W-1:0] fifo_count;
  logic [CNT_W:0]   occupancy;

  // decode
  assign dec_press   = (scancode <= PRESS_MAX);
  assign dec_release = (scancode >= RELEASE_MIN) && (scancode <= RELEASE_MAX);
  assign dec_key     = key_code_lookup(scancode[6:0]);
  assign dec_ok      = (dec_press || dec_release) && (int'(scancode[6:0]) < KEY_COUNT)
                       && (dec_key != 8'd0);

  assign occupancy = (CNT_W + 1)'(fifo_count) + (s1_valid ? (CNT_W + 1)'(2) : '0);
  assign in_ready  = (occupancy <= (CNT_W + 1)'(EVQ_DEPTH - 2));
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept && dec_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_press <= dec_press;
      s1_idx   <= scancode[IDX_W-1:0];
      s1_key   <= dec_key;
    end
  end

  scte_key_mem #(
    .KEY_COUNT(KEY_COUNT)
  ) u_key_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (in_accept && dec_ok),
    .rd_addr(scancode[IDX_W-1:0]),
    .rd_bit (mem_rd_bit),
    .wr_en  (s1_valid),
    .wr_addr(s1_idx),
    .wr_bit (s1_press)
  );

  // latest write bypasses a read issued at the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_valid) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fwd_idx <= s1_idx;
      fwd_bit <= s1_press;
    end
  end

  assign down = (fwd_valid && (fwd_idx == s1_idx)) ? fwd_bit : mem_rd_bit;

  always_comb begin
    key_val  = VAL_RELEASE;
    push_n   = 2'd0;
    set_last = 1'b0;
    if (s1_valid) begin
      if (s1_press && !down) begin
        key_val  = VAL_PRESS;
        push_n   = 2'd2;
        set_last = 1'b1;
      end else if (s1_press) begin
        key_val = VAL_REPEAT;
        push_n  = (s1_key == last_pressed) ? 2'd2 : 2'd0;
      end else if (down) begin
        push_n = 2'd2;
      end else begin
        push_n = 2'd1;
      end
    end
  end

  always_comb begin
    push_w1 = '{etype: TYPE_SYNC, code: 8'd0, value: VAL_RELEASE, last: 1'b1};
    if (push_n == 2'd2) begin
      push_w0 = '{etype: TYPE_KEY, code: s1_key, value: key_val, last: 1'b0};
    end else begin
      push_w0 = push_w1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pressed <= 8'd0;
    end else if (set_last) begin
      last_pressed <= s1_key;
    end
  end

  scte_event_fifo #(
    .DEPTH(EVQ_DEPTH)
  ) u_event_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_n   (push_n),
    .push_w0  (push_w0),
    .push_w1  (push_w1),
    .pop_valid(out_valid),
    .pop_ready(out_ready),
    .head     (head),
    .count    (fifo_count)
  );

  assign event_type  = head.etype;
  assign event_code  = head.code;
  assign event_value = head.value;
  assign last_of_run = head.last;

  a_s1_from_accept: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $past(in_accept && dec_ok))
    else $error("stage 1 word without accepted scancode");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (fifo_count <= CNT_W'(EVQ_DEPTH - 2)))
    else $error("event queue lacks room for stage 1");

  a_repeat_last: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd2 && key_val == VAL_REPEAT) |-> (s1_key == last_pressed))
    else $error("repeat for a key that was not last pressed");

  a_word_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((event_type == TYPE_KEY) != last_of_run))
    else $error("key event and run end disagree");

endmodule

// ----- design/scte_key_mem.sv -----
// Key down map: one-bit synchronous memory with registered read and
// per-entry valid flops cleared by reset. Depends on scte_pkg.
module scte_key_mem
  import scte_pkg::*;
#(
  parameter int KEY_COUNT = KEY_COUNT_DEF,
  localparam int IDX_W = $clog2(KEY_COUNT)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic             rd_bit,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic             wr_bit
);

  logic                 mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] valid;
  logic                 rd_data;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  // never-written entries read as not down
  assign rd_bit = rd_valid & rd_data;

endmodule

// ----- design/scte_event_fifo.sv -----
// Event word queue: takes up to two words per cycle, hands out one while pop_ready is high.
// Depends on scte_pkg.
module scte_event_fifo
  import scte_pkg::*;
#(
  parameter int DEPTH = EVQ_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  event_word_t      push_w0,
  input  event_word_t      push_w1,
  output logic             pop_valid,
  input  logic             pop_ready,
  output event_word_t      head,
  output logic [CNT_W-1:0] count
);

  event_word_t            entries [DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic                   pop;

  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= push_w0;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= push_w1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

endmodule

// ----- dv/tb_scancode_to_key_event.sv -----
// Testbench for scancode_to_key_event: drives set-1 scancode words, predicts the
// key and sync event words in a local model, and checks them in order.
// Depends on scte_pkg and the scancode_to_key_event RTL.
module tb_scancode_to_key_event;
  import scte_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEYS        = KEY_COUNT_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int TARGET_KEYS = 600;
  localparam int MAX_PRINTS  = 100;

  typedef struct {
    logic [7:0] code;
    bit         drain;
  } pending_word_t;

  logic       clk;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] scancode    = 8'h00;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic       event_type;
  logic [7:0] event_code;
  logic [1:0] event_value;
  logic       last_of_run;

  pending_word_t scancode_queue[$];
  event_word_t   event_queue[$];

  logic [7:0] linux_code [0:KEYS-1];
  logic [KEYS-1:0] held_keys = '0;
  logic [7:0] recent_press_code = '0;

  int mismatch_count = 0;
  int idle_cycles    = 0;
  int in_count       = 0;
  int useful_count   = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int hold_left      = 0;
  int hold_mark      = -1;
  bit tx_fast        = 1'b0;
  bit rx_fast        = 1'b0;

  scancode_to_key_event DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .scancode   (scancode),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_type (event_type),
    .event_code (event_code),
    .event_value(event_value),
    .last_of_run(last_of_run)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t ns: %s got %0h, want %0h", $time, field, got, want);
    mismatch_count++;
  endtask

  function automatic bit is_key_word(input logic [7:0] sc);
    int idx;
    if (sc <= PRESS_MAX) idx = sc;
    else if (sc >= RELEASE_MIN && sc <= RELEASE_MAX) idx = sc - RELEASE_MIN;
    else return 1'b0;
    return linux_code[idx] != 8'd0;
  endfunction

  task automatic queue_scancode(input logic [7:0] sc, input bit drain = 1'b0);
    pending_word_t w;
    w.code  = sc;
    w.drain = drain;
    scancode_queue.push_back(w);
    if (is_key_word(sc)) useful_count++;
  endtask

  // Key event (if any) then sync word, or nothing; down bit updated last.
  task automatic predict_key_events(input logic [7:0] sc);
    bit         is_press;
    int         idx;
    logic [7:0] key;
    event_word_t ev;
    if (sc <= PRESS_MAX) begin
      is_press = 1'b1;
      idx = sc;
    end else if (sc >= RELEASE_MIN && sc <= RELEASE_MAX) begin
      is_press = 1'b0;
      idx = sc - RELEASE_MIN;
    end else begin
      return;
    end
    if (idx >= KEYS) return;
    key = linux_code[idx];
    if (key == 8'd0) return;
    if (is_press && held_keys[idx] && key != recent_press_code) return;
    if (is_press || held_keys[idx]) begin
      ev.etype = TYPE_KEY;
      ev.code  = key;
      ev.last  = 1'b0;
      if (!is_press) ev.value = VAL_RELEASE;
      else if (held_keys[idx]) ev.value = VAL_REPEAT;
      else ev.value = VAL_PRESS;
      event_queue.push_back(ev);
    end
    if (is_press && !held_keys[idx]) recent_press_code = key;
    ev.etype = TYPE_SYNC;
    ev.code  = '0;
    ev.value = '0;
    ev.last  = 1'b1;
    event_queue.push_back(ev);
    held_keys[idx] = is_press;
  endtask

  // driver
  logic       nxt_valid;
  logic [7:0] nxt_code;
  int         nxt_gap;
  pending_word_t head;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      nxt_valid = in_valid;
      nxt_code  = scancode;
      nxt_gap   = gap_left;
      if (in_valid && in_ready) begin
        predict_key_events(scancode);
        in_count <= in_count + 1;
        nxt_valid = 1'b0;
        nxt_gap   = tx_fast ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 47) == 0) tx_fast = !tx_fast;
      end
      if (!nxt_valid) begin
        if (nxt_gap > 0) begin
          nxt_gap--;
        end else if (scancode_queue.size() > 0 &&
                     !(scancode_queue[0].drain && event_queue.size() > 0)) begin
          head = scancode_queue.pop_front();
          nxt_code  = head.code;
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
      scancode <= nxt_code;
      gap_left <= nxt_gap;
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left == 0 && (in_count == 200 || in_count == 450) &&
                 hold_mark != in_count) begin
      hold_left <= HOLD_CYCLES;
      hold_mark <= in_count;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  event_word_t want;
  int          nxt_stall;

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      nxt_stall = stall_left;
      if (out_valid && out_ready) begin
        if (event_queue.size() == 0) begin
          report_mismatch("unexpected word, event_code", event_code, 0);
        end else begin
          want = event_queue.pop_front();
          if (event_type !== want.etype) report_mismatch("event_type", event_type, want.etype);
          if (event_code !== want.code) report_mismatch("event_code", event_code, want.code);
          if (event_value !== want.value)
            report_mismatch("event_value", event_value, want.value);
          if (last_of_run !== want.last) report_mismatch("last_of_run", last_of_run, want.last);
        end
        nxt_stall = rx_fast ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 63) == 0) rx_fast = !rx_fast;
      end else if (nxt_stall > 0) begin
        nxt_stall--;
      end
      stall_left <= nxt_stall;
      out_ready  <= (nxt_stall == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // stimulus and end of run
  int         pick;
  int         key_a;
  int         key_b;
  int         reps;
  logic [7:0] noise;

  initial begin
    for (int i = 0; i < KEYS; i++) linux_code[i] = i[7:0];
    linux_code[0]  = 8'd0;
    linux_code[84] = 8'd0;
    linux_code[85] = 8'd0;
    linux_code[86] = 8'd0;
    linux_code[72] = 8'd103;
    linux_code[75] = 8'd105;
    linux_code[77] = 8'd106;
    linux_code[80] = 8'd108;
    linux_code[82] = 8'd110;
    linux_code[83] = 8'd111;

    // unmapped keys, unused codes, then press/repeat/release corners
    queue_scancode(8'h00);
    queue_scancode(8'h54);
    queue_scancode(8'h55);
    queue_scancode(8'h56);
    queue_scancode(RELEASE_MIN);
    queue_scancode(8'hD6);
    queue_scancode(8'h59);
    queue_scancode(8'h7F);
    queue_scancode(8'hD9);
    queue_scancode(8'hFF);
    queue_scancode(8'h01);
    queue_scancode(8'h01);
    queue_scancode(8'h02);
    queue_scancode(8'h01);
    queue_scancode(8'h81);
    queue_scancode(8'h81);
    queue_scancode(PRESS_MAX);
    queue_scancode(8'h48);
    queue_scancode(8'h48);
    queue_scancode(RELEASE_MAX);
    queue_scancode(8'hC8);
    queue_scancode(8'h82);
    queue_scancode(8'h53);
    queue_scancode(8'hD3);

    // sender waits for the directed part to drain
    queue_scancode(8'h10, 1'b1);
    queue_scancode(8'h90);

    while (useful_count < TARGET_KEYS) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        noise = 8'($urandom_range(0, 255));
        queue_scancode(noise);
      end else if (pick < 25) begin
        key_a = $urandom_range(0, KEYS - 1);
        queue_scancode(key_a[7:0], $urandom_range(0, 39) == 0);
      end else begin
        key_a = $urandom_range(1, KEYS - 1);
        queue_scancode(key_a[7:0], $urandom_range(0, 39) == 0);
        if ($urandom_range(0, 2) == 0) begin
          key_b = $urandom_range(1, KEYS - 1);
          queue_scancode(key_b[7:0]);
          queue_scancode(key_a[7:0]);
          queue_scancode(key_b[7:0] | RELEASE_MIN);
        end
        reps = $urandom_range(0, 3);
        for (int r = 0; r < reps; r++) queue_scancode(key_a[7:0]);
        if ($urandom_range(0, 7) != 0) queue_scancode(key_a[7:0] | RELEASE_MIN);
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (scancode_queue.size() != 0 || in_valid) @(posedge clk);
    while (event_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
